### rtl/core/tpid_pkg.sv
// ----------------------------------------------------------------------------
// tpid_pkg
// Shared types and codes of the triggered PID controller pipeline.
// ----------------------------------------------------------------------------
package tpid_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_TOGGLE = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  localparam logic [1:0] CFG_BASELINE = 2'd0;
  localparam logic [1:0] CFG_GAIN_P   = 2'd1;
  localparam logic [1:0] CFG_GAIN_I   = 2'd2;
  localparam logic [1:0] CFG_GAIN_D   = 2'd3;

  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_LOAD,
    KIND_PID
  } tpid_kind_e;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [23:0] target;
    logic signed [23:0] measured;
  } tpid_in_t;

  typedef struct packed {
    tpid_kind_e         kind;
    logic               enabled;
    logic signed [24:0] err;
    logic signed [39:0] isum;
    logic signed [25:0] derr;
  } tpid_err_t;

  typedef struct packed {
    tpid_kind_e         kind;
    logic               enabled;
    logic signed [48:0] prod_p;
    logic signed [43:0] prod_ihi;
    logic signed [44:0] prod_ilo;
    logic signed [49:0] prod_d;
  } tpid_prod_t;

endpackage

### rtl/core/tpid_integrator.sv
// ----------------------------------------------------------------------------
// tpid_integrator
// Error, saturating integrator, derivative and enable flag; one stage.
// ----------------------------------------------------------------------------
module tpid_integrator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpid_pkg::tpid_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpid_pkg::tpid_err_t out_o
);

  logic signed [39:0] integ_q, integ_d;
  logic signed [24:0] prev_err_q, prev_err_d;
  logic               flag_q, flag_d;
  logic               valid_q;
  tpid_pkg::tpid_err_t stage_q, stage_d;

  logic               fire;
  logic signed [24:0] err;
  logic signed [40:0] isum_raw;
  logic signed [39:0] isum;
  logic signed [25:0] derr;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    err      = {in_i.target[23], in_i.target} - {in_i.measured[23], in_i.measured};
    isum_raw = {integ_q[39], integ_q} + {{16{err[24]}}, err};
    if (isum_raw[40] != isum_raw[39]) begin
      isum = isum_raw[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      isum = isum_raw[39:0];
    end
    derr = {err[24], err} - {prev_err_q[24], prev_err_q};
  end

  always_comb begin
    integ_d        = integ_q;
    prev_err_d     = prev_err_q;
    flag_d         = flag_q;
    stage_d.kind   = tpid_pkg::KIND_HOLD;
    stage_d.err    = err;
    stage_d.isum   = isum;
    stage_d.derr   = derr;
    unique case (in_i.op)
      tpid_pkg::OP_UPDATE: begin
        if (flag_q) begin
          stage_d.kind = tpid_pkg::KIND_PID;
          integ_d      = isum;
          prev_err_d   = err;
        end
      end
      tpid_pkg::OP_TOGGLE: begin
        flag_d = !flag_q;
      end
      tpid_pkg::OP_REINIT: begin
        stage_d.kind = tpid_pkg::KIND_LOAD;
        integ_d      = '0;
        prev_err_d   = '0;
        flag_d       = 1'b1;
      end
      default: begin
      end
    endcase
    stage_d.enabled = flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
      flag_q     <= 1'b1;
      valid_q    <= 1'b0;
    end else begin
      if (fire) begin
        integ_q    <= integ_d;
        prev_err_q <= prev_err_d;
        flag_q     <= flag_d;
      end
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      stage_q <= stage_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = stage_q;

  a_reinit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.op == tpid_pkg::OP_REINIT) |=>
    (integ_q == '0 && prev_err_q == '0 && flag_q))
    else $error("reinit left integrator state");

  a_toggle_flips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.op == tpid_pkg::OP_TOGGLE) |=> (flag_q != $past(flag_q)))
    else $error("toggle did not flip enable");

  a_frozen_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.op == tpid_pkg::OP_UPDATE && !flag_q) |=>
    ($stable(integ_q) && $stable(prev_err_q)))
    else $error("disabled update changed state");

endmodule

### rtl/core/tpid_multiply.sv
// ----------------------------------------------------------------------------
// tpid_multiply
// Gain products of the three terms; integral product split in two halves.
// ----------------------------------------------------------------------------
module tpid_multiply (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tpid_pkg::tpid_err_t  in_i,
  input  logic signed [23:0]   gain_p_i,
  input  logic signed [23:0]   gain_i_i,
  input  logic signed [23:0]   gain_d_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tpid_pkg::tpid_prod_t out_o
);

  logic                 valid_q;
  tpid_pkg::tpid_prod_t stage_q, stage_d;
  logic                 fire;
  logic signed [20:0]   isum_lo;
  logic signed [19:0]   isum_hi;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    isum_lo          = {1'b0, in_i.isum[19:0]};
    isum_hi          = in_i.isum[39:20];
    stage_d.kind     = in_i.kind;
    stage_d.enabled  = in_i.enabled;
    stage_d.prod_p   = gain_p_i * in_i.err;
    stage_d.prod_ihi = gain_i_i * isum_hi;
    stage_d.prod_ilo = gain_i_i * isum_lo;
    stage_d.prod_d   = gain_d_i * in_i.derr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      stage_q <= stage_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = stage_q;

endmodule

### rtl/core/tpid_output.sv
// ----------------------------------------------------------------------------
// tpid_output
// Round and sum the terms with the baseline, saturate, and hold the controller output; reinit loads the baseline.
// ----------------------------------------------------------------------------
module tpid_output (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tpid_pkg::tpid_prod_t in_i,
  input  logic signed [31:0]   baseline_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   drive_value_o,
  output logic                 enabled_o
);

  logic               valid_q;
  logic signed [31:0] held_q, held_d;
  logic               enabled_q;
  logic               fire;

  logic signed [49:0] p_round;
  logic signed [64:0] i_full;
  logic signed [64:0] i_round;
  logic signed [50:0] d_round;
  logic signed [50:0] total;
  logic signed [31:0] total_sat;

  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    p_round = {in_i.prod_p[48], in_i.prod_p} + 50'sd32768;
    i_full  = {in_i.prod_ihi[43], in_i.prod_ihi, 20'd0}
            + {{20{in_i.prod_ilo[44]}}, in_i.prod_ilo};
    i_round = i_full + 65'sd32768;
    d_round = {in_i.prod_d[49], in_i.prod_d} + 51'sd32768;
    total   = {{19{baseline_i[31]}}, baseline_i}
            + {{17{p_round[49]}}, p_round[49:16]}
            + {{2{i_round[64]}}, i_round[64:16]}
            + {{16{d_round[50]}}, d_round[50:16]};
    if (total[50:31] != {20{total[50]}}) begin
      total_sat = total[50] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      total_sat = total[31:0];
    end
  end

  always_comb begin
    unique case (in_i.kind)
      tpid_pkg::KIND_PID:  held_d = total_sat;
      tpid_pkg::KIND_LOAD: held_d = baseline_i;
      default:             held_d = held_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      held_q    <= '0;
      enabled_q <= 1'b1;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (fire) begin
        held_q    <= held_d;
        enabled_q <= in_i.enabled;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign drive_value_o = held_q;
  assign enabled_o     = enabled_q;

  a_hold_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.kind == tpid_pkg::KIND_HOLD) |=> $stable(held_q))
    else $error("hold transaction changed output");

  a_load_baseline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.kind == tpid_pkg::KIND_LOAD) |=> (held_q == $past(baseline_i)))
    else $error("reinit did not load baseline");

endmodule

### rtl/core/triggered_pid_controller_top.sv
// ----------------------------------------------------------------------------
// triggered_pid_controller_top
// Event-driven fixed-point PID controller: input register, integrator stage,
// product stage, and a rounding/saturating output stage.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o    operation, target, measured
//   out      source     out_valid_o/out_ready_i  drive_value, enabled
//   cfg      sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction per cycle unless the output stalls. The integrator and
// previous-error registers close their loop within the integrator stage.
// Reset: gains and baseline 0, integrator 0, output 0, enabled 1.
// A stalled output backs up stage by stage; empty stages keep accepting.
// ----------------------------------------------------------------------------
module triggered_pid_controller_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [23:0] target_value_i,
  input  logic signed [23:0] measured_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] drive_value_o,
  output logic               enabled_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic signed [31:0] baseline_q;
  logic signed [23:0] gain_p_q, gain_i_q, gain_d_q;

  logic                 in_valid_q;
  tpid_pkg::tpid_in_t   in_q;
  logic                 int_ready;
  logic                 err_valid, err_ready;
  tpid_pkg::tpid_err_t  err_stage;
  logic                 prod_valid, prod_ready;
  tpid_pkg::tpid_prod_t prod_stage;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= '0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tpid_pkg::CFG_BASELINE: baseline_q <= cfg_data_i;
        tpid_pkg::CFG_GAIN_P:   gain_p_q   <= cfg_data_i[23:0];
        tpid_pkg::CFG_GAIN_I:   gain_i_q   <= cfg_data_i[23:0];
        tpid_pkg::CFG_GAIN_D:   gain_d_q   <= cfg_data_i[23:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready_o = !in_valid_q || int_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q.op       <= operation_i;
      in_q.target   <= target_value_i;
      in_q.measured <= measured_value_i;
    end
  end

  tpid_integrator u_integrator (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_ready_o  (int_ready),
    .in_i        (in_q),
    .out_valid_o (err_valid),
    .out_ready_i (err_ready),
    .out_o       (err_stage)
  );

  tpid_multiply u_multiply (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (err_valid),
    .in_ready_o  (err_ready),
    .in_i        (err_stage),
    .gain_p_i    (gain_p_q),
    .gain_i_i    (gain_i_q),
    .gain_d_i    (gain_d_q),
    .out_valid_o (prod_valid),
    .out_ready_i (prod_ready),
    .out_o       (prod_stage)
  );

  tpid_output u_output (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (prod_valid),
    .in_ready_o    (prod_ready),
    .in_i          (prod_stage),
    .baseline_i    (baseline_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_value_o (drive_value_o),
    .enabled_o     (enabled_o)
  );

endmodule
